// ===== rtl/shj_pkg.sv =====
// ----------------------------------------------------------------------------
// shj_pkg
// Shared types, constants and helpers for the sample histogram and jitter
// block.
// ----------------------------------------------------------------------------
package shj_pkg;

   localparam int SAMPLE_WIDTH        = 12;
   localparam int STAMP_WIDTH         = 32;
   localparam int LIMIT_WIDTH         = 16;
   localparam int TAKEN_WIDTH         = 16;
   localparam int OUT_COUNT_WIDTH     = 16;

   localparam int BIN_COUNT_DEFAULT   = 4096;
   localparam int COUNT_WIDTH_DEFAULT = 16;

   localparam logic [LIMIT_WIDTH-1:0]  LIMIT_RESET = 16'd1000;
   localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_TOP  = 12'hFFF;

   // operation codes carried in tuser
   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_READ   = 1'b1;

   // running statistics
   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] min_sample;
      logic [SAMPLE_WIDTH-1:0] max_sample;
      logic [STAMP_WIDTH-1:0]  min_interval;
      logic [STAMP_WIDTH-1:0]  max_interval;
      logic [TAKEN_WIDTH-1:0]  samples_taken;
   } stats_type;

   // magnitude of the wrapped difference, read as signed
   function automatic logic [STAMP_WIDTH-1:0] abs_interval(
      input logic [STAMP_WIDTH-1:0] now_ts,
      input logic [STAMP_WIDTH-1:0] prev_ts
   );
      logic [STAMP_WIDTH-1:0] diff;
      diff = now_ts - prev_ts;
      if (diff[STAMP_WIDTH-1]) begin
         diff = '0 - diff;
      end
      return diff;
   endfunction

endpackage

// ===== rtl/sample_histogram_and_jitter_top.sv =====
// ----------------------------------------------------------------------------
// sample_histogram_and_jitter_top
// Histogram of 12-bit samples with min/max sample and timestamp interval
// tracking; read-modify-write of the bin memory with forwarding.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_tvalid/req_tready  | tdata: sample, stamp, bin; tuser: op
//  rsp     | out       | rsp_tvalid/rsp_tready  | tdata: count and statistics
//  csr     | in        | csr_valid/csr_ready    | csr_data: sample limit
//
// One word per cycle sustained while rsp is not stalled; the bin memory read is
// issued at the accepting edge, the update stage then updates and writes back
// the bin, and the result word is loaded into the output register when it advances.
// A write and a read of the same bin in one cycle are forwarded.
// After reset a clearing sweep zeroes every bin, during which req_tready
// stays low; csr writes are always taken.
// A stall on rsp holds the update stage and the input side behind it.
// ----------------------------------------------------------------------------
module sample_histogram_and_jitter_top #(
   parameter int BIN_COUNT   = shj_pkg::BIN_COUNT_DEFAULT,
   parameter int COUNT_WIDTH = shj_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   // sample_value[11:0], timestamp[43:12], bin_index[55:44]
   input  logic [55:0]  req_tdata,
   // operation[0]
   input  logic [0:0]   req_tuser,
   input  logic         req_tvalid,
   output logic         req_tready,
   // bin_count[15:0], min_sample[27:16], max_sample[39:28],
   // min_interval[71:40], max_interval[103:72], jitter[135:104],
   // samples_taken[151:136], capture_done[152], zero[159:153]
   output logic [159:0] rsp_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [shj_pkg::LIMIT_WIDTH-1:0] csr_data,
   input  logic         csr_valid,
   output logic         csr_ready
);
   import shj_pkg::*;

   localparam int ADDR_WIDTH = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_CEIL = '1;

   // input unpacking
   logic                    in_op;
   logic [SAMPLE_WIDTH-1:0] in_value;
   logic [STAMP_WIDTH-1:0]  in_stamp;
   logic [SAMPLE_WIDTH-1:0] in_bin;
   logic [SAMPLE_WIDTH-1:0] in_sel;
   logic [31:0]             in_sel_ext;
   logic [ADDR_WIDTH-1:0]   in_addr;
   logic                    in_has_bin;

   logic accept, advance, s1_go, clear_busy;

   // limit register
   logic [LIMIT_WIDTH-1:0] limit_ff;

   // update stage
   logic                    s1_valid_ff;
   logic                    s1_op_ff;
   logic [SAMPLE_WIDTH-1:0] s1_value_ff;
   logic [STAMP_WIDTH-1:0]  s1_stamp_ff;
   logic [ADDR_WIDTH-1:0]   s1_addr_ff;
   logic                    s1_has_bin_ff;
   logic                    s1_fwd_hit_ff;
   logic [COUNT_WIDTH-1:0]  s1_fwd_data_ff;

   logic [COUNT_WIDTH-1:0]  rd_data, cur_count, inc_count, new_count;
   logic [31:0]             new_count_ext;
   logic                    keep, wr_en;

   stats_type stats_cur, stats_upd;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [OUT_COUNT_WIDTH-1:0] out_count_ff;
   stats_type                  out_stats_ff;
   logic                       out_done_ff;
   logic [STAMP_WIDTH-1:0]     out_jitter;

   assign in_op    = req_tuser[0];
   assign in_value = req_tdata[11:0];
   assign in_stamp = req_tdata[43:12];
   assign in_bin   = req_tdata[55:44];

   // pick the bin to address and check it exists
   assign in_sel     = (in_op == OP_RECORD) ? in_value : in_bin;
   assign in_sel_ext = {{(32-SAMPLE_WIDTH){1'b0}}, in_sel};
   assign in_addr    = in_sel_ext[ADDR_WIDTH-1:0];
   assign in_has_bin = in_sel_ext < 32'(BIN_COUNT);

   // handshake
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign s1_go      = s1_valid_ff && advance;
   assign req_tready = !clear_busy && (!s1_valid_ff || advance);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_data;
      end
   end

   // bin memory
   shj_bin_store #(
      .BIN_COUNT   (BIN_COUNT),
      .COUNT_WIDTH (COUNT_WIDTH),
      .ADDR_WIDTH  (ADDR_WIDTH)
   ) u_bins (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (in_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (new_count),
      .busy    (clear_busy)
   );

   // load the update stage; capture a same-cycle write to the bin being read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff       <= in_op;
         s1_value_ff    <= in_value;
         s1_stamp_ff    <= in_stamp;
         s1_addr_ff     <= in_addr;
         s1_has_bin_ff  <= in_has_bin;
         s1_fwd_hit_ff  <= wr_en && (s1_addr_ff == in_addr);
         s1_fwd_data_ff <= new_count;
      end
   end

   // modify: saturating increment of the bin for a kept sample
   assign keep      = (s1_op_ff == OP_RECORD) &&
                      (stats_cur.samples_taken < limit_ff);
   assign cur_count = s1_fwd_hit_ff ? s1_fwd_data_ff : rd_data;
   assign inc_count = (cur_count == COUNT_CEIL) ? cur_count : cur_count + 1'b1;

   always_comb begin
      new_count = '0;
      if (s1_has_bin_ff) begin
         new_count = keep ? inc_count : cur_count;
      end
   end

   assign new_count_ext = 32'(new_count);
   assign wr_en         = s1_go && keep && s1_has_bin_ff;

   // running statistics
   shj_stats u_stats (
      .clock     (clock),
      .reset     (reset),
      .upd       (s1_go && keep),
      .sample    (s1_value_ff),
      .stamp     (s1_stamp_ff),
      .stats_cur (stats_cur),
      .stats_upd (stats_upd)
   );

   // hold the result until taken
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         out_count_ff <= new_count_ext[OUT_COUNT_WIDTH-1:0];
         out_stats_ff <= stats_upd;
         out_done_ff  <= stats_upd.samples_taken >= limit_ff;
      end
   end

   assign out_jitter = (out_stats_ff.samples_taken >= 2) ?
                       out_stats_ff.max_interval - out_stats_ff.min_interval : '0;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0,
                        out_done_ff,
                        out_stats_ff.samples_taken,
                        out_jitter,
                        out_stats_ff.max_interval,
                        out_stats_ff.min_interval,
                        out_stats_ff.max_sample,
                        out_stats_ff.min_sample,
                        out_count_ff};

`ifndef SYNTHESIS
   a_no_word_in_sweep : assert property (@(posedge clock) disable iff (reset)
      accept |-> !clear_busy)
      else $error("word taken during bin clearing");
   a_stage_holds : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_addr_ff))
      else $error("update stage lost a stalled word");
   a_count_steps : assert property (@(posedge clock) disable iff (reset)
      s1_go && keep |=> stats_cur.samples_taken == $past(stats_cur.samples_taken) + 1'b1)
      else $error("kept sample not counted");
`endif

endmodule

// ===== rtl/shj_bin_store.sv =====
// ----------------------------------------------------------------------------
// shj_bin_store
// Histogram bin memory: one write port, one registered read port, and a
// clearing sweep after reset that zeroes every bin, one per cycle.
// ----------------------------------------------------------------------------
module shj_bin_store #(
   parameter int BIN_COUNT   = 4096,
   parameter int COUNT_WIDTH = 16,
   parameter int ADDR_WIDTH  = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rd_en,
   input  logic [ADDR_WIDTH-1:0]  rd_addr,
   output logic [COUNT_WIDTH-1:0] rd_data,
   input  logic                   wr_en,
   input  logic [ADDR_WIDTH-1:0]  wr_addr,
   input  logic [COUNT_WIDTH-1:0] wr_data,
   output logic                   busy
);

   localparam logic [ADDR_WIDTH-1:0] LAST_ADDR = ADDR_WIDTH'(BIN_COUNT - 1);

   logic [COUNT_WIDTH-1:0] mem [BIN_COUNT];
   logic [COUNT_WIDTH-1:0] rd_data_ff;
   logic                   busy_ff, busy_in;
   logic [ADDR_WIDTH-1:0]  clr_addr_ff, clr_addr_in;

   // advance the clearing sweep
   always_comb begin
      busy_in     = busy_ff;
      clr_addr_in = clr_addr_ff;
      if (busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_ADDR) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         busy_ff     <= busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // write port, shared with the sweep
   always_ff @(posedge clock) begin
      if (busy_ff && !reset) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

// ===== rtl/shj_stats.sv =====
// ----------------------------------------------------------------------------
// shj_stats
// Running minimum and maximum of kept samples and of the intervals between
// their timestamps, plus the count of kept samples.
// ----------------------------------------------------------------------------
module shj_stats (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            upd,
   input  logic [shj_pkg::SAMPLE_WIDTH-1:0] sample,
   input  logic [shj_pkg::STAMP_WIDTH-1:0]  stamp,
   output shj_pkg::stats_type               stats_cur,
   output shj_pkg::stats_type               stats_upd
);
   import shj_pkg::*;

   stats_type              stats_ff, stats_in;
   logic [STAMP_WIDTH-1:0] prev_ts_ff, prev_ts_in;
   logic [STAMP_WIDTH-1:0] interval;

   assign interval = abs_interval(stamp, prev_ts_ff);

   // fold in one kept sample
   always_comb begin
      stats_in   = stats_ff;
      prev_ts_in = prev_ts_ff;
      if (upd) begin
         if (sample < stats_ff.min_sample) begin
            stats_in.min_sample = sample;
         end
         if (sample > stats_ff.max_sample) begin
            stats_in.max_sample = sample;
         end
         if (stats_ff.samples_taken != '0) begin
            if (interval < stats_ff.min_interval) begin
               stats_in.min_interval = interval;
            end
            if (interval > stats_ff.max_interval) begin
               stats_in.max_interval = interval;
            end
         end
         prev_ts_in             = stamp;
         stats_in.samples_taken = stats_ff.samples_taken + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stats_ff.min_sample    <= SAMPLE_TOP;
         stats_ff.max_sample    <= '0;
         stats_ff.min_interval  <= '1;
         stats_ff.max_interval  <= '0;
         stats_ff.samples_taken <= '0;
         prev_ts_ff             <= '0;
      end else begin
         stats_ff   <= stats_in;
         prev_ts_ff <= prev_ts_in;
      end
   end

   assign stats_cur = stats_ff;
   assign stats_upd = stats_in;

`ifndef SYNTHESIS
   a_min_le_max : assert property (@(posedge clock) disable iff (reset)
      stats_ff.samples_taken != '0 |-> stats_ff.min_sample <= stats_ff.max_sample)
      else $error("minimum sample above maximum");
   a_iv_order : assert property (@(posedge clock) disable iff (reset)
      stats_ff.samples_taken >= 2 |-> stats_ff.min_interval <= stats_ff.max_interval)
      else $error("minimum interval above maximum");
   a_empty : assert property (@(posedge clock) disable iff (reset)
      stats_ff.samples_taken == '0 |->
         stats_ff.min_sample == SAMPLE_TOP && stats_ff.max_sample == '0)
      else $error("extremes moved with no sample taken");
`endif

endmodule

// ===== dv/sample_histogram_and_jitter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_histogram_and_jitter_checker
// Scoreboard for the sample histogram block. It watches the req, rsp and csr
// channels and keeps its own copy of the bins, the limit and the running
// statistics. Each accepted request word is turned into a predicted result
// word, and each result word is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module sample_histogram_and_jitter_checker (
   input  logic         clock,
   input  logic         reset,
   // sample_value[11:0], timestamp[43:12], bin_index[55:44]
   input  logic [55:0]  req_tdata,
   // operation[0]
   input  logic [0:0]   req_tuser,
   input  logic         req_tvalid,
   input  logic         req_tready,
   // bin_count[15:0], min_sample[27:16], max_sample[39:28],
   // min_interval[71:40], max_interval[103:72], jitter[135:104],
   // samples_taken[151:136], capture_done[152], zero[159:153]
   input  logic [159:0] rsp_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [15:0]  csr_data,
   input  logic         csr_valid,
   input  logic         csr_ready,
   output int           errors,
   output int           pending
);
   import shj_pkg::*;

   // same bit order as rsp_tdata[152:0]
   typedef struct packed {
      logic        capture_done;
      logic [15:0] samples_taken;
      logic [31:0] jitter;
      logic [31:0] max_interval;
      logic [31:0] min_interval;
      logic [11:0] max_sample;
      logic [11:0] min_sample;
      logic [15:0] bin_count;
   } tally_report_type;

   logic [15:0]      bin_copy [4096];
   logic [31:0]      prev_stamp;
   logic [15:0]      taken;
   logic [15:0]      limit;
   logic [11:0]      low_sample;
   logic [11:0]      high_sample;
   logic [31:0]      low_gap;
   logic [31:0]      high_gap;
   tally_report_type reports_due [$];

   // apply one request word to the mirrored state and return its result
   function automatic tally_report_type tally_word(input logic op,
                                                   input logic [11:0] value,
                                                   input logic [31:0] stamp,
                                                   input logic [11:0] bin);
      tally_report_type r;
      logic [31:0]      gap;
      if (op == OP_RECORD) begin
         // samples beyond the limit leave everything as it is
         if (taken < limit) begin
            if (bin_copy[value] != 16'hFFFF) begin
               bin_copy[value] = bin_copy[value] + 16'd1;
            end
            if (value < low_sample) begin
               low_sample = value;
            end
            if (value > high_sample) begin
               high_sample = value;
            end
            // the first sample only leaves its stamp behind
            if (taken != 16'd0) begin
               gap = stamp - prev_stamp;
               if (gap[31]) begin
                  gap = 32'd0 - gap;
               end
               if (gap < low_gap) begin
                  low_gap = gap;
               end
               if (gap > high_gap) begin
                  high_gap = gap;
               end
            end
            prev_stamp = stamp;
            taken      = taken + 16'd1;
         end
         r.bin_count = bin_copy[value];
      end else begin
         r.bin_count = bin_copy[bin];
      end
      r.min_sample    = low_sample;
      r.max_sample    = high_sample;
      r.min_interval  = low_gap;
      r.max_interval  = high_gap;
      r.jitter        = (taken >= 16'd2) ? high_gap - low_gap : 32'd0;
      r.samples_taken = taken;
      r.capture_done  = (taken >= limit);
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         errors++;
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      end
   endtask

   initial begin
      errors  = 0;
      pending = 0;
   end

   // sample all three channels at the rising edge
   always @(posedge clock) begin
      tally_report_type want;
      tally_report_type got;
      if (reset) begin
         foreach (bin_copy[i]) begin
            bin_copy[i] = '0;
         end
         prev_stamp  = '0;
         taken       = '0;
         limit       = LIMIT_RESET;
         low_sample  = 12'hFFF;
         high_sample = '0;
         low_gap     = '1;
         high_gap    = '0;
         reports_due.delete();
      end else begin
         // take a new limit
         if (csr_valid && csr_ready) begin
            limit = csr_data;
         end
         // match the result word against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[152:0];
            if (reports_due.size() == 0) begin
               errors++;
               $error("result word with no prediction waiting");
            end else begin
               want = reports_due.pop_front();
               check_field("bin_count", want.bin_count, got.bin_count);
               check_field("min_sample", want.min_sample, got.min_sample);
               check_field("max_sample", want.max_sample, got.max_sample);
               check_field("min_interval", want.min_interval, got.min_interval);
               check_field("max_interval", want.max_interval, got.max_interval);
               check_field("jitter", want.jitter, got.jitter);
               check_field("samples_taken", want.samples_taken, got.samples_taken);
               check_field("capture_done", want.capture_done, got.capture_done);
            end
         end
         // predict the result of an accepted request word
         if (req_tvalid && req_tready) begin
            reports_due.push_back(tally_word(req_tuser[0], req_tdata[11:0],
                                             req_tdata[43:12], req_tdata[55:44]));
         end
      end
      pending = reports_due.size();
   end

endmodule

// ===== dv/sample_histogram_and_jitter_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_histogram_and_jitter_top_tb
// Drives the sample histogram block with a directed opening (empty reads,
// stamp wrap, half-range and zero intervals, capture ended, blocked and
// resumed by limit writes) and then with phases of random record and read
// words under changing limits, with random gaps on the input and random
// stalls on the output. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module sample_histogram_and_jitter_top_tb;
   import shj_pkg::*;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic [55:0]  req_tdata  = '0;
   logic [0:0]   req_tuser  = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [159:0] rsp_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [15:0]  csr_data   = '0;
   logic         csr_valid  = 1'b0;
   logic         csr_ready;
   int           errors;
   int           pending;

   // stimulus shaping state
   logic         calm        = 1'b0;
   logic [15:0]  taken_seen  = '0;
   logic [15:0]  limit_set   = LIMIT_RESET;
   logic [11:0]  last_value  = '0;
   int           stall_left  = 0;

   always #10 clock = ~clock;

   sample_histogram_and_jitter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   sample_histogram_and_jitter_checker tally_check (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .errors     (errors),
      .pending    (pending)
   );

   // stall the result side, mostly briefly, now and then for long
   always @(negedge clock) begin
      int r;
      if (calm) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(3, 40);
         end
      end
   end

   // hold off a random gap, then offer one word until it is taken
   task automatic push_word(input logic op, input logic [11:0] value,
                            input logic [31:0] stamp, input logic [11:0] bin);
      int gap;
      int r;
      gap = 0;
      if (!calm) begin
         r = $urandom_range(0, 99);
         if (r >= 90) begin
            gap = $urandom_range(4, 40);
         end else if (r >= 60) begin
            gap = $urandom_range(1, 3);
         end
      end
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tdata  <= {bin, stamp, value};
      req_tuser  <= op;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (op == OP_RECORD) begin
         if (taken_seen < limit_set) begin
            taken_seen++;
         end
         last_value = value;
      end
   endtask

   // write the limit once every outstanding result has come back
   task automatic write_limit(input logic [15:0] value);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      limit_set = value;
   endtask

   initial begin
      logic        op;
      logic [11:0] value;
      logic [11:0] bin;
      logic [11:0] hot;
      logic [31:0] stamp;
      logic [31:0] base_period;
      logic [15:0] next_limit;
      int          r;
      int          wait_n;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty histogram, stamp wrap, half range and zero intervals
      push_word(OP_READ,   12'h000, 32'h0000_0000, 12'h000);
      push_word(OP_READ,   12'hFFF, 32'hFFFF_FFFF, 12'hFFF);
      push_word(OP_RECORD, 12'h000, 32'h0000_0000, 12'hFFF);
      push_word(OP_RECORD, 12'hFFF, 32'hFFFF_FFFF, 12'h000);
      push_word(OP_RECORD, 12'h800, 32'h7FFF_FFFF, 12'h000);
      push_word(OP_RECORD, 12'h800, 32'h7FFF_FFFF, 12'h000);
      push_word(OP_RECORD, 12'hFFF, 32'h8000_0010, 12'h000);
      push_word(OP_RECORD, 12'h001, 32'h0000_0005, 12'h000);
      push_word(OP_READ,   12'h000, 32'h0000_0000, 12'h800);
      push_word(OP_READ,   12'h000, 32'h0000_0000, 12'hFFF);
      push_word(OP_READ,   12'h000, 32'h0000_0000, 12'h000);
      push_word(OP_READ,   12'h000, 32'h0000_0000, 12'h001);
      // a limit at the present count ends the capture at once
      write_limit(taken_seen);
      push_word(OP_RECORD, 12'h007, 32'h0000_1000, 12'h000);
      push_word(OP_RECORD, 12'h800, 32'h0000_2000, 12'h000);
      push_word(OP_READ,   12'h000, 32'h0000_0000, 12'h800);
      // a limit of zero blocks everything
      write_limit(16'd0);
      push_word(OP_RECORD, 12'h800, 32'h0000_3000, 12'h000);
      // raising the limit resumes the capture
      write_limit(16'hFFFF);
      push_word(OP_RECORD, 12'hBB8, 32'h1234_5678, 12'h000);
      write_limit(taken_seen + 16'd1);
      push_word(OP_RECORD, 12'h005, 32'h1234_6000, 12'h000);
      push_word(OP_RECORD, 12'h006, 32'h1234_7000, 12'h000);
      write_limit(16'd1);
      push_word(OP_RECORD, 12'h009, 32'h1234_8000, 12'h000);

      // random phases, each under a limit of its own
      stamp = $urandom;
      for (int ph = 0; ph < 14; ph++) begin
         if (ph == 0) begin
            next_limit = 16'hFFFF;
         end else begin
            case ($urandom_range(0, 7))
               0:       next_limit = 16'hFFFF;
               1:       next_limit = 16'd1;
               2:       next_limit = taken_seen;
               3, 4, 5: next_limit = taken_seen + 16'($urandom_range(10, 90));
               6:       next_limit = 16'($urandom_range(1, 65535));
               default: next_limit = 16'd0;
            endcase
         end
         calm = ($urandom_range(0, 3) == 0);
         write_limit(next_limit);
         hot         = 12'($urandom_range(0, 4088));
         base_period = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(16, 5000);

         for (int n = 0; n < 96; n++) begin
            // mostly steady stamps with some jitter, some jumps and steps back
            r = $urandom_range(0, 99);
            if (r < 70) begin
               stamp = stamp + base_period + $urandom_range(0, 63) - 32'd32;
            end else if (r < 80) begin
               stamp = $urandom;
            end else if (r < 88) begin
               stamp = stamp - $urandom_range(1, 5000);
            end else if (r < 94) begin
               stamp = stamp + 32'h8000_0000;
            end

            // cluster samples around a hot spot so bins build up
            r = $urandom_range(0, 99);
            if (r < 45) begin
               value = hot + 12'($urandom_range(0, 7));
            end else if (r < 55) begin
               value = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            end else begin
               value = 12'($urandom_range(0, 4095));
            end

            r = $urandom_range(0, 99);
            if (r < 50) begin
               bin = last_value;
            end else if (r < 60) begin
               bin = hot + 12'($urandom_range(0, 7));
            end else if (r < 70) begin
               bin = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            end else begin
               bin = 12'($urandom_range(0, 4095));
            end

            op = ($urandom_range(0, 9) < 3) ? OP_READ : OP_RECORD;
            push_word(op, value, stamp, bin);
         end
      end

      // drain, then keep watching for stray words before the final check
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait_n = 0;
      while (pending != 0 && wait_n < 5000) begin
         @(negedge clock);
         wait_n++;
      end
      repeat (8) @(negedge clock);
      if (pending != 0) begin
         $error("%0d predicted results never arrived", pending);
      end
      if (errors == 0 && pending == 0) begin
         $display("** sample_histogram_and_jitter_top: PASSED **");
      end else begin
         $display("** sample_histogram_and_jitter_top: FAILED **");
      end
      $finish;
   end

   // hard stop well beyond the slowest correct run
   initial begin
      #10_000_000;
      $display("** sample_histogram_and_jitter_top: FAILED **");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/shj_pkg.sv
rtl/shj_bin_store.sv
rtl/shj_stats.sv
rtl/sample_histogram_and_jitter_top.sv
dv/sample_histogram_and_jitter_checker.sv
dv/sample_histogram_and_jitter_top_tb.sv
